// File: rtl/core/wsd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// wsd_pkg
// Shared types and constants of the websocket frame deframer.
// ============================================================================
package wsd_pkg;

   localparam int LENGTH_BITS_DEF = 64;
   localparam int BYTE_W          = 8;
   localparam int OPCODE_W        = 4;
   localparam int PAYLOAD_LEN_W   = 64;
   localparam int CNT_W           = 4;
   localparam int KEY_W           = 32;

   localparam logic [6:0]       LEN7_EXT16   = 7'd126;
   localparam logic [6:0]       LEN7_EXT64   = 7'd127;
   localparam logic [CNT_W-1:0] EXT16_BYTES  = 4'd2;
   localparam logic [CNT_W-1:0] EXT64_BYTES  = 4'd8;
   localparam logic [CNT_W-1:0] KEY_BYTES    = 4'd4;
   localparam logic [CNT_W-1:0] CNT_LAST     = 4'd1;

   typedef enum logic [1:0] {
      KIND_HDR = 2'd0,
      KIND_PAY = 2'd1,
      KIND_ERR = 2'd2
   } wsd_kind_type;

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_SECOND  = 3'd1,
      PH_EXT     = 3'd2,
      PH_KEY     = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_DROP    = 3'd5
   } wsd_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_buffer;
   } wsd_req_type;

   typedef struct packed {
      wsd_kind_type             kind;
      logic                     fin;
      logic [OPCODE_W-1:0]      opcode;
      logic                     masked;
      logic [PAYLOAD_LEN_W-1:0] payload_length;
      logic [BYTE_W-1:0]        out_byte;
      logic                     last;
   } wsd_rsp_type;

   typedef struct packed {
      logic has_rsp;
      logic has_err;
   } wsd_step_type;

   localparam wsd_rsp_type RSP_ERR = '{
      kind:           KIND_ERR,
      fin:            1'b0,
      opcode:         '0,
      masked:         1'b0,
      payload_length: '0,
      out_byte:       '0,
      last:           1'b0
   };

endpackage

// File: rtl/core/wsd_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// wsd_parser
// Frame header parser and payload unmasker: one byte per advance, gives the
// result word of that byte and whether an error word follows it.
// ============================================================================
module wsd_parser #(
   parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  wsd_pkg::wsd_req_type req,
   output wsd_pkg::wsd_step_type step,
   output wsd_pkg::wsd_rsp_type rsp
);
   import wsd_pkg::*;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   wsd_phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic                   ovf_ff, ovf_in;
   logic [LENGTH_BITS-1:0] idx_ff, idx_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic                   fin_ff, fin_in;
   logic                   masked_ff, masked_in;
   logic [OPCODE_W-1:0]    opcode_ff, opcode_in;

   logic [BYTE_W-1:0]      b;
   logic [6:0]             l7;
   logic                   short_len;
   logic                   masked_now;
   logic                   after_len;
   logic                   key_done;
   logic                   finish;
   logic [LENGTH_BITS-1:0] len_shift;
   logic [LENGTH_BITS-1:0] len_src;
   logic                   ovf_src;
   logic [LENGTH_BITS-1:0] len_fin;
   logic                   empty;
   logic [LENGTH_BITS-1:0] idx_inc;
   logic                   pay_last;
   wsd_phase_type          phase_step;

   // shared decode
   always_comb begin
      b          = req.in_byte;
      l7         = b[6:0];
      short_len  = (l7 != LEN7_EXT16) && (l7 != LEN7_EXT64);
      masked_now = (phase_ff == PH_SECOND) ? b[7] : masked_ff;
      len_shift  = {len_ff[LENGTH_BITS-BYTE_W-1:0], b};
      after_len  = ((phase_ff == PH_SECOND) && short_len) ||
                   ((phase_ff == PH_EXT) && (cnt_ff == CNT_LAST));
      key_done   = (phase_ff == PH_KEY) && (cnt_ff == CNT_LAST);
      finish     = (after_len && !masked_now) || key_done;
      len_src    = len_ff;
      ovf_src    = ovf_ff;
      if (phase_ff == PH_SECOND) begin
         len_src = LENGTH_BITS'(l7);
         ovf_src = 1'b0;
      end else if (phase_ff == PH_EXT) begin
         len_src = len_shift;
         ovf_src = ovf_ff | (|len_ff[LENGTH_BITS-1 -: BYTE_W]);
      end
      len_fin  = ovf_src ? LEN_MAX : len_src;
      empty    = (len_fin == '0);
      idx_inc  = idx_ff + 1'b1;
      pay_last = (idx_inc >= len_ff);
   end

   // next state
   always_comb begin
      phase_step = phase_ff;
      cnt_in     = cnt_ff;
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      idx_in     = idx_ff;
      key_in     = key_ff;
      fin_in     = fin_ff;
      masked_in  = masked_ff;
      opcode_in  = opcode_ff;
      unique case (phase_ff)
         PH_FIRST: begin
            fin_in     = b[7];
            opcode_in  = b[OPCODE_W-1:0];
            masked_in  = 1'b0;
            key_in     = '0;
            len_in     = '0;
            ovf_in     = 1'b0;
            idx_in     = '0;
            phase_step = PH_SECOND;
         end
         PH_SECOND: begin
            masked_in = b[7];
            if (l7 == LEN7_EXT16) begin
               cnt_in     = EXT16_BYTES;
               len_in     = '0;
               ovf_in     = 1'b0;
               phase_step = PH_EXT;
            end else if (l7 == LEN7_EXT64) begin
               cnt_in     = EXT64_BYTES;
               len_in     = '0;
               ovf_in     = 1'b0;
               phase_step = PH_EXT;
            end else begin
               len_in = len_src;
               ovf_in = ovf_src;
               if (masked_now) begin
                  cnt_in     = KEY_BYTES;
                  phase_step = PH_KEY;
               end
            end
         end
         PH_EXT: begin
            len_in = len_src;
            ovf_in = ovf_src;
            cnt_in = cnt_ff - 1'b1;
            if (after_len && masked_now) begin
               cnt_in     = KEY_BYTES;
               phase_step = PH_KEY;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[KEY_W-BYTE_W-1:0], b};
            cnt_in = cnt_ff - 1'b1;
         end
         PH_PAYLOAD: begin
            idx_in = idx_inc;
            key_in = {key_ff[KEY_W-BYTE_W-1:0], key_ff[KEY_W-1 -: BYTE_W]};
            if (pay_last) begin
               phase_step = PH_DROP;
            end
         end
         PH_DROP: begin
         end
         default: begin
            phase_step = PH_FIRST;
         end
      endcase
      if (finish) begin
         len_in     = len_fin;
         ovf_in     = 1'b0;
         idx_in     = '0;
         phase_step = empty ? PH_DROP : PH_PAYLOAD;
      end
      phase_in = phase_step;
      if (req.end_of_buffer) begin
         phase_in = PH_FIRST;
         cnt_in   = '0;
      end
   end

   // result word
   always_comb begin
      step.has_rsp = finish || (phase_ff == PH_PAYLOAD);
      step.has_err = req.end_of_buffer && (phase_step != PH_DROP);
      rsp.kind           = KIND_HDR;
      rsp.fin            = fin_ff;
      rsp.opcode         = opcode_ff;
      rsp.masked         = masked_now;
      rsp.payload_length = PAYLOAD_LEN_W'(len_fin);
      rsp.out_byte       = '0;
      rsp.last           = empty;
      if (phase_ff == PH_PAYLOAD) begin
         rsp.kind           = KIND_PAY;
         rsp.payload_length = PAYLOAD_LEN_W'(len_ff);
         rsp.out_byte       = b ^ key_ff[KEY_W-1 -: BYTE_W];
         rsp.last           = pay_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         cnt_ff    <= '0;
         len_ff    <= '0;
         ovf_ff    <= 1'b0;
         idx_ff    <= '0;
         key_ff    <= '0;
         fin_ff    <= 1'b0;
         masked_ff <= 1'b0;
         opcode_ff <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         idx_ff    <= idx_in;
         key_ff    <= key_in;
         fin_ff    <= fin_in;
         masked_ff <= masked_in;
         opcode_ff <= opcode_in;
      end
   end

endmodule

// File: rtl/core/websocket_frame_deframer.sv
`timescale 1ns / 1ps
// ============================================================================
// websocket_frame_deframer
// Parses a websocket frame header from a byte stream and unmasks its payload.
// ----------------------------------------------------------------------------
// req channel: one buffer byte per word, end_of_buffer on the last byte.
// rsp channel: header word once the header is complete, one word per payload
//   byte (unmasked, last on the final byte), and an error word when the
//   buffer ends before the frame is complete. Bytes after the payload give
//   no word; each buffer starts a new frame.
// Path: each byte is held in the input register, and its word in the result
//   register, which drives rsp.
// Throughput: one byte per cycle while rsp is not stalled. A byte that
//   yields a word and ends an incomplete frame gives two words and holds
//   the input side while the result register sends the error word.
// Stall: the input register takes one more byte while a word waits on a
//   stalled rsp; then req_stall rises until rsp moves with no error pending.
// Reset: synchronous; clears both valid flags and the pending error, and
//   returns the parser to expecting the first header byte.
// ============================================================================
module websocket_frame_deframer #(
   parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  wsd_pkg::wsd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wsd_pkg::wsd_rsp_type rsp_data
);
   import wsd_pkg::*;

   logic         in_valid_ff, in_valid_in;
   wsd_req_type  in_ff;
   logic         out_valid_ff, out_valid_in;
   wsd_rsp_type  out_ff, out_in;
   logic         err_pend_ff, err_pend_in;

   logic         out_free;
   logic         go;
   logic         accept_in;
   wsd_step_type step;
   wsd_rsp_type  step_rsp;

   wsd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (go),
      .req     (in_ff),
      .step    (step),
      .rsp     (step_rsp)
   );

   assign out_free  = !out_valid_ff || (!rsp_stall && !err_pend_ff);
   assign go        = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !go;
   assign accept_in = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      err_pend_in  = err_pend_ff;
      if (go) begin
         in_valid_in = 1'b0;
      end
      if (accept_in) begin
         in_valid_in = 1'b1;
      end
      // drain the current word
      if (out_valid_ff && !rsp_stall) begin
         if (err_pend_ff) begin
            out_in      = RSP_ERR;
            err_pend_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (go) begin
         if (step.has_rsp) begin
            out_valid_in = 1'b1;
            out_in       = step_rsp;
            err_pend_in  = step.has_err;
         end else if (step.has_err) begin
            out_valid_in = 1'b1;
            out_in       = RSP_ERR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         err_pend_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         err_pend_ff  <= err_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_ff <= req_data;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
